// File: design/fbprr_pkg.sv
// Shared types, constants and helper functions of the free-block pool.
`default_nettype none

package fbprr_pkg;

    // Pool geometry
    localparam int FLASH_COUNT      = 8;
    localparam int BLOCKS_PER_FLASH = 4096;
    localparam int PLANE_COUNT      = 2;

    localparam int NUM_Q        = PLANE_COUNT * FLASH_COUNT;
    localparam int Q_CAP        = (BLOCKS_PER_FLASH + PLANE_COUNT - 1) / PLANE_COUNT;
    localparam int MEM_DEPTH    = NUM_Q * Q_CAP;
    localparam int TOTAL_BLOCKS = FLASH_COUNT * BLOCKS_PER_FLASH;

    // Field widths of the beats
    localparam int CMD_W   = 1;
    localparam int FLASH_W = 3;
    localparam int BLK_W   = 12;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 16;

    // Internal widths
    localparam int Q_W    = (NUM_Q > 1) ? $clog2(NUM_Q) : 1;
    localparam int POS_W  = (Q_CAP > 1) ? $clog2(Q_CAP) : 1;
    localparam int CNT_W  = $clog2(Q_CAP + 1);
    localparam int ADDR_W = $clog2(MEM_DEPTH);
    localparam int FREE_W = $clog2(TOTAL_BLOCKS + 1);
    localparam int RR_W   = 2 * NUM_Q;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TAKE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_PUT  = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [FLASH_W-1:0] flash_index;
        logic [BLK_W-1:0]   block_index;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [FLASH_W-1:0] flash_out;
        logic [BLK_W-1:0]   block_out;
        logic [COUNT_W-1:0] free_count;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_stat_t;

    // Number of blocks a queue holds after reset
    function automatic int init_count(input logic [Q_W-1:0] q);
        int plane;
        plane = 32'(q) / FLASH_COUNT;
        return (BLOCKS_PER_FLASH - plane + PLANE_COUNT - 1) / PLANE_COUNT;
    endfunction

endpackage

`default_nettype wire

// File: design/fbprr_ctrl.sv
// Sequencing state machine of the free-block pool.
`default_nettype none

module fbprr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fbprr_pkg::dp_stat_t stat,
    output fbprr_pkg::dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_LOAD = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Take a beat when idle, or when the finished result moves out
    always_comb begin
        s_ready = (state_reg == ST_IDLE) || ((state_reg == ST_LOAD) && stat.out_free);
    end

    always_comb begin
        cmd.capture = s_valid && s_ready;
        cmd.exec    = (state_reg == ST_EXEC);
        cmd.load    = (state_reg == ST_LOAD) && stat.out_free;
    end

    // Advance through execute and load, hold in load while the output is full
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (stat.out_free) begin
                    state_next = s_valid ? ST_EXEC : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: design/fbprr_dp.sv
// Datapath of the free-block pool: queue pointers, block memory, search, result register.
`default_nettype none

module fbprr_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fbprr_pkg::in_item_t  s_data,
    input  fbprr_pkg::dp_cmd_t   cmd,
    output fbprr_pkg::dp_stat_t  stat,
    input  logic                 m_ready,
    output logic                 m_valid,
    output fbprr_pkg::out_item_t m_data
);

    localparam int Q_W    = fbprr_pkg::Q_W;
    localparam int POS_W  = fbprr_pkg::POS_W;
    localparam int CNT_W  = fbprr_pkg::CNT_W;
    localparam int ADDR_W = fbprr_pkg::ADDR_W;
    localparam int FREE_W = fbprr_pkg::FREE_W;
    localparam int RR_W   = fbprr_pkg::RR_W;
    localparam int BLK_W  = fbprr_pkg::BLK_W;
    localparam int FL_W   = fbprr_pkg::FLASH_W;
    localparam int NQ     = fbprr_pkg::NUM_Q;
    localparam int QCAP   = fbprr_pkg::Q_CAP;

    // Architectural state
    fbprr_pkg::in_item_t  in_reg;
    logic [POS_W-1:0]     head_reg [NQ];
    logic [CNT_W-1:0]     count_reg [NQ];
    logic [CNT_W-1:0]     wr_cnt_reg [NQ];
    logic [FREE_W-1:0]    free_reg;
    logic [Q_W-1:0]       ptr_reg;
    logic [BLK_W-1:0]     mem [fbprr_pkg::MEM_DEPTH];
    logic [BLK_W-1:0]     rd_data_reg;

    // Result held between execute and load
    logic [fbprr_pkg::STAT_W-1:0] res_status_reg;
    logic                         res_grant_reg;
    logic [FL_W-1:0]              res_flash_reg;
    logic                         res_use_mem_reg;
    logic [BLK_W-1:0]             res_init_reg;

    logic                 m_valid_reg;
    fbprr_pkg::out_item_t m_data_reg;

    // Combinational
    logic [NQ-1:0]     nonempty;
    logic [RR_W-1:0]   dbl;
    logic [RR_W-1:0]   low_mask;
    logic [RR_W-1:0]   cand;
    logic [RR_W-1:0]   first;
    logic [Q_W-1:0]    rr_q;
    logic [Q_W-1:0]    put_q;
    logic [Q_W-1:0]    sel_q;
    logic              is_take;
    logic              can_take;
    logic              in_range;
    logic              can_put;
    logic              do_take;
    logic              do_put;
    logic [POS_W-1:0]  cur_head;
    logic [CNT_W-1:0]  cur_count;
    logic [CNT_W-1:0]  cur_wr;
    logic [CNT_W:0]    tail_sum;
    logic [POS_W-1:0]  tail_pos;
    logic [POS_W-1:0]  access_pos;
    logic [ADDR_W-1:0] mem_addr;
    logic [POS_W-1:0]  tail0;
    logic [CNT_W-1:0]  rel;
    logic              written;
    logic [BLK_W-1:0]  init_val;
    logic [POS_W-1:0]  head_inc;
    logic [Q_W-1:0]    ptr_inc;

    // Flag the queues that hold blocks
    always_comb begin
        for (int i = 0; i < NQ; i++) begin
            nonempty[i] = (count_reg[i] != '0);
        end
    end

    // Round-robin search: lowest set bit at or above the pointer in a doubled vector
    always_comb begin
        dbl      = {nonempty, nonempty};
        low_mask = (RR_W'(1) << ptr_reg) - RR_W'(1);
        cand     = dbl & ~low_mask;
        first    = cand & (~cand + RR_W'(1));
        rr_q     = '0;
        for (int j = 0; j < RR_W; j++) begin
            if (first[j]) begin
                rr_q = rr_q | Q_W'(j % NQ);
            end
        end
    end

    // Pick the queue and its ring position
    always_comb begin
        is_take  = (in_reg.cmd == fbprr_pkg::CMD_TAKE);
        can_take = (free_reg != '0);
        in_range = (32'(in_reg.flash_index) < fbprr_pkg::FLASH_COUNT)
                && (32'(in_reg.block_index) < fbprr_pkg::BLOCKS_PER_FLASH);
        put_q    = Q_W'(32'(in_reg.block_index % fbprr_pkg::PLANE_COUNT)
                   * fbprr_pkg::FLASH_COUNT + 32'(in_reg.flash_index));
        sel_q    = is_take ? rr_q : put_q;

        cur_head  = head_reg[sel_q];
        cur_count = count_reg[sel_q];
        cur_wr    = wr_cnt_reg[sel_q];
        can_put   = in_range && (cur_count < CNT_W'(QCAP));

        tail_sum = (CNT_W+1)'(cur_head) + (CNT_W+1)'(cur_count);
        if (tail_sum >= (CNT_W+1)'(QCAP)) begin
            tail_pos = POS_W'(tail_sum - (CNT_W+1)'(QCAP));
        end else begin
            tail_pos = POS_W'(tail_sum);
        end
        access_pos = is_take ? cur_head : tail_pos;
        mem_addr   = ADDR_W'(sel_q) * ADDR_W'(QCAP) + ADDR_W'(access_pos);

        do_take = cmd.exec && is_take && can_take;
        do_put  = cmd.exec && !is_take && can_put;
    end

    // Decide whether the head entry was overwritten since reset, else rebuild its reset value
    always_comb begin
        tail0 = POS_W'(fbprr_pkg::init_count(sel_q) % QCAP);
        if (cur_head >= tail0) begin
            rel = CNT_W'(cur_head - tail0);
        end else begin
            rel = CNT_W'(cur_head) + CNT_W'(QCAP) - CNT_W'(tail0);
        end
        written  = (rel < cur_wr);
        init_val = BLK_W'(32'(sel_q) / fbprr_pkg::FLASH_COUNT
                   + 32'(cur_head) * fbprr_pkg::PLANE_COUNT);
        head_inc = (cur_head == POS_W'(QCAP - 1)) ? '0 : cur_head + POS_W'(1);
        ptr_inc  = (rr_q == Q_W'(NQ - 1)) ? '0 : rr_q + Q_W'(1);
    end

    // Update queue bookkeeping and the output valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NQ; i++) begin
                head_reg[i]   <= '0;
                count_reg[i]  <= CNT_W'(fbprr_pkg::init_count(Q_W'(i)));
                wr_cnt_reg[i] <= '0;
            end
            free_reg    <= FREE_W'(fbprr_pkg::TOTAL_BLOCKS);
            ptr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (do_take) begin
                head_reg[sel_q]  <= head_inc;
                count_reg[sel_q] <= cur_count - CNT_W'(1);
                free_reg         <= free_reg - FREE_W'(1);
                ptr_reg          <= ptr_inc;
            end
            if (do_put) begin
                count_reg[sel_q] <= cur_count + CNT_W'(1);
                free_reg         <= free_reg + FREE_W'(1);
                if (cur_wr < CNT_W'(QCAP)) begin
                    wr_cnt_reg[sel_q] <= cur_wr + CNT_W'(1);
                end
            end
            if (cmd.load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Block memory: write on insert, registered read on take
    always_ff @(posedge aclk) begin
        if (do_put) begin
            mem[mem_addr] <= in_reg.block_index;
        end
        if (do_take) begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    // Hold the input beat, then the partial result, then the output beat
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg <= s_data;
        end
        if (cmd.exec) begin
            res_flash_reg   <= FL_W'(sel_q % fbprr_pkg::FLASH_COUNT);
            res_use_mem_reg <= written;
            res_init_reg    <= init_val;
            res_grant_reg   <= is_take && can_take;
            if (is_take) begin
                res_status_reg <= can_take ? fbprr_pkg::ST_OK : fbprr_pkg::ST_EMPTY;
            end else begin
                res_status_reg <= can_put ? fbprr_pkg::ST_OK : fbprr_pkg::ST_FULL;
            end
        end
        if (cmd.load) begin
            m_data_reg.status     <= res_status_reg;
            m_data_reg.flash_out  <= res_grant_reg ? res_flash_reg : '0;
            m_data_reg.block_out  <= res_grant_reg
                                     ? (res_use_mem_reg ? rd_data_reg : res_init_reg) : '0;
            m_data_reg.free_count <= fbprr_pkg::COUNT_W'(free_reg);
        end
    end

    assign stat.out_free = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_data        = m_data_reg;

endmodule

`default_nettype wire

// File: design/free_block_pool_round_robin_top.sv
// Top level of the free-block pool: per-plane, per-chip FIFO queues served round robin.
//
// Input channel s_*: one beat per request. cmd 0 takes a free block, cmd 1 returns
// block_index of chip flash_index to the queue of its plane and chip.
// Result channel m_*: exactly one beat per request, in request order, with a status
// (ok, no free block, insert dropped), the granted chip and block, and the number of
// free blocks after the request.
// A request is captured, then passes the queue-select and block-memory access step
// and then the result load step, after which its result is valid on m_*; the
// single-port block memory is touched once per request.
// The next request is taken in the same cycle its predecessor's result is loaded;
// if the result register is still full, the block holds in the load step and
// deasserts s_ready until m_ready drains it.
// Reset: aresetn low for one clock puts every block into its queue in ascending
// order. The memory is not swept: entries not yet overwritten since reset are
// rebuilt from their ring position, so requests are taken right after reset.
`default_nettype none

module free_block_pool_round_robin_top (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  fbprr_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output fbprr_pkg::out_item_t m_data
);

    fbprr_pkg::dp_cmd_t  cmd;
    fbprr_pkg::dp_stat_t stat;

    fbprr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    fbprr_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

    // A taken beat goes straight to execute, so no second beat is taken next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (cmd.exec && !s_ready))
        else $error("request not executed after being taken");

    // A loaded result is presented on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> m_valid)
        else $error("loaded result not presented");

    // An empty-pool result grants nothing and reports zero free blocks
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status == fbprr_pkg::ST_EMPTY)) |->
        ((m_data.free_count == '0) && (m_data.flash_out == '0) && (m_data.block_out == '0)))
        else $error("empty-pool result carries a grant or a nonzero count");

endmodule

`default_nettype wire

// File: test/tb_free_block_pool_round_robin_top.sv
`timescale 1ns / 100ps
// Testbench of the round-robin free-block pool: take and return traffic checked against a pool model.

module tb_free_block_pool_round_robin_top;
    import fbprr_pkg::*;

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 11;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS  = 10;
    localparam int MIXED_ITEMS  = 1200;
    localparam int BURST_ITEMS  = 200;
    localparam int TAIL_ITEMS   = 280;
    localparam int SETTLE       = 8;

    typedef struct {
        in_item_t    beat;
        int unsigned gap;
    } request_t;

    typedef struct packed {
        logic [FLASH_W-1:0] chip;
        logic [BLK_W-1:0]   blk;
    } block_ref_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    in_item_t  s_data  = '0;
    logic      m_ready = 1'b0;
    logic      s_ready;
    logic      m_valid;
    out_item_t m_data;

    // Pool model: one ring of block numbers per (plane, chip) queue
    logic [BLK_W-1:0] ring_mem [NUM_Q][Q_CAP];
    int unsigned      ring_head [NUM_Q];
    int unsigned      ring_len  [NUM_Q];
    int unsigned      pool_free;
    int unsigned      free_low;
    int unsigned      rr_ptr;

    request_t   request_q  [$];
    out_item_t  rsp_owed_q [$];
    block_ref_t lent_q     [$];

    // Driver state
    request_t    staged;
    bit          have_staged = 1'b0;
    int unsigned gap_left    = 0;
    bit          beat_taken  = 1'b0;

    // Receiver state
    int unsigned stall_left = 0;
    int unsigned hold_left  = 0;
    bit          hold_req   = 1'b0;
    bit          rx_calm    = 1'b0;
    int unsigned calm_timer = 0;

    // Bookkeeping
    int unsigned queued_total   = 0;
    int unsigned accepted_total = 0;
    int unsigned rsp_seen       = 0;
    int unsigned drain_lo       = 0;
    int unsigned drain_hi       = 0;
    int unsigned mism_count     = 0;
    int unsigned stray_count    = 0;
    int unsigned grants         = 0;
    int unsigned empty_hits     = 0;
    int unsigned returns_ok     = 0;
    int unsigned drops          = 0;
    int unsigned holds_done     = 0;
    longint      cycle_no       = 0;
    longint      cycle_budget   = HOLD_CYCLES + RESET_CYCLES;

    free_block_pool_round_robin_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Apply one request to the pool model and return the response it owes
    function automatic out_item_t serve_request(input in_item_t req);
        out_item_t   rsp;
        int unsigned q;
        int unsigned slot;
        int          i;
        bit          found;
        rsp = '0;
        if (req.cmd == CMD_TAKE) begin
            rsp.status = ST_EMPTY;
            found = 1'b0;
            if (pool_free != 0) begin
                // Skip empty queues starting at the round-robin pointer
                q = rr_ptr % NUM_Q;
                for (i = 0; i < NUM_Q; i++) begin
                    if (!found) begin
                        if (ring_len[q] != 0)
                            found = 1'b1;
                        else
                            q = (q + 1) % NUM_Q;
                    end
                end
            end
            if (found) begin
                rsp.status    = ST_OK;
                rsp.flash_out = FLASH_W'(q % FLASH_COUNT);
                rsp.block_out = ring_mem[q][ring_head[q]];
                ring_head[q]  = (ring_head[q] + 1) % Q_CAP;
                ring_len[q]--;
                pool_free--;
                rr_ptr = (q + 1) % NUM_Q;
                lent_q.push_back('{chip: rsp.flash_out, blk: rsp.block_out});
                grants++;
            end else begin
                empty_hits++;
            end
        end else if (32'(req.flash_index) >= FLASH_COUNT ||
                     32'(req.block_index) >= BLOCKS_PER_FLASH) begin
            rsp.status = ST_FULL;
            drops++;
        end else begin
            q = (32'(req.block_index) % PLANE_COUNT) * FLASH_COUNT + 32'(req.flash_index);
            if (ring_len[q] >= Q_CAP) begin
                rsp.status = ST_FULL;
                drops++;
            end else begin
                // Append at the ring tail; duplicates go in like any other block
                slot = (ring_head[q] + ring_len[q]) % Q_CAP;
                ring_mem[q][slot] = req.block_index;
                ring_len[q]++;
                pool_free++;
                rsp.status = ST_OK;
                returns_ok++;
            end
        end
        if (pool_free < free_low)
            free_low = pool_free;
        rsp.free_count = COUNT_W'(pool_free);
        return rsp;
    endfunction

    // Queue one request beat with a random idle gap ahead of it
    task automatic queue_request(input logic [CMD_W-1:0] cmd, input logic [FLASH_W-1:0] chip,
                                 input logic [BLK_W-1:0] blk, input bit light, input bit calm);
        request_t    item;
        int unsigned r;
        item.beat.cmd         = cmd;
        item.beat.flash_index = chip;
        item.beat.block_index = blk;
        r = $urandom_range(99);
        if (calm || r < 70)
            item.gap = 0;
        else if (r < 95 || light)
            item.gap = $urandom_range(3, 1);
        else
            item.gap = $urandom_range(40, 10);
        request_q.push_back(item);
        queued_total++;
        cycle_budget += 2 + item.gap + (light ? 3 : 40);
    endtask

    // Mix of takes, returns of granted blocks, and random returns
    task automatic queue_mixed(input int unsigned n, input int unsigned take_pct,
                               input int unsigned ret_pct);
        int unsigned done;
        int unsigned r;
        int unsigned idx;
        bit          calm;
        block_ref_t  pick;
        calm = 1'b0;
        for (done = 0; done < n; done++) begin
            while (request_q.size() >= 8)
                @(posedge aclk);
            if (done % 16 == 0)
                calm = ($urandom_range(3) == 0);
            r = $urandom_range(99);
            if (r < take_pct) begin
                queue_request(CMD_TAKE, FLASH_W'($urandom), BLK_W'($urandom), 1'b0, calm);
            end else if (r < take_pct + ret_pct && lent_q.size() != 0) begin
                idx  = $urandom_range(lent_q.size() - 1);
                pick = lent_q[idx];
                lent_q.delete(idx);
                queue_request(CMD_PUT, pick.chip, pick.blk, 1'b0, calm);
            end else begin
                queue_request(CMD_PUT, FLASH_W'($urandom), BLK_W'($urandom), 1'b0, calm);
            end
        end
    endtask

    // Wait until every queued beat is taken and every response has come back
    task automatic wait_drained();
        while (accepted_total != queued_total || rsp_owed_q.size() != 0)
            @(posedge aclk);
    endtask

    // Check result beats in order, then book accepted request beats
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                rsp_seen++;
                if (rsp_owed_q.size() == 0) begin
                    stray_count++;
                    if (stray_count + mism_count <= MAX_REPORTS)
                        $display("Unexpected result beat: status %0d chip %0d block %0d free %0d",
                                 m_data.status, m_data.flash_out, m_data.block_out,
                                 m_data.free_count);
                end else begin
                    want = rsp_owed_q.pop_front();
                    if (m_data.status !== want.status || m_data.flash_out !== want.flash_out ||
                        m_data.block_out !== want.block_out ||
                        m_data.free_count !== want.free_count) begin
                        mism_count++;
                        if (stray_count + mism_count <= MAX_REPORTS)
                            $display("Result %0d mismatch (got/want): status %0d/%0d chip %0d/%0d %s",
                                     rsp_seen - 1, m_data.status, want.status, m_data.flash_out,
                                     want.flash_out,
                                     $sformatf("block %0d/%0d free %0d/%0d", m_data.block_out,
                                               want.block_out, m_data.free_count,
                                               want.free_count));
                    end
                end
            end
            if (s_valid && s_ready) begin
                beat_taken = 1'b1;
                accepted_total++;
                rsp_owed_q.push_back(serve_request(s_data));
            end
        end
    end

    // Drive request beats: hold until taken, then advance after the gap
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || beat_taken)) begin
            beat_taken = 1'b0;
            if (!have_staged && request_q.size() != 0) begin
                staged      = request_q.pop_front();
                have_staged = 1'b1;
                gap_left    = staged.gap;
            end
            if (have_staged && gap_left == 0) begin
                s_valid     <= 1'b1;
                s_data      <= staged.beat;
                have_staged = 1'b0;
            end else begin
                s_valid <= 1'b0;
                if (have_staged)
                    gap_left--;
            end
        end
    end

    // Receiver: random stalls, calm windows and one long hold-off on request
    always @(negedge aclk) begin
        bit          light;
        int unsigned r;
        light = (rsp_seen >= drain_lo) && (rsp_seen < drain_hi);
        calm_timer++;
        if (calm_timer % 300 == 0)
            rx_calm = ($urandom_range(3) == 0);
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            holds_done++;
            m_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (rx_calm) begin
            m_ready <= 1'b1;
        end else begin
            r = $urandom_range(99);
            if (r < 70) begin
                m_ready <= 1'b1;
            end else begin
                if (r < 95 || light)
                    stall_left = $urandom_range(3, 1) - 1;
                else
                    stall_left = $urandom_range(40, 10) - 1;
                m_ready <= 1'b0;
            end
        end
    end

    // Cycle count and timeout
    always @(posedge aclk) begin
        cycle_no++;
        if (cycle_no > 4 * cycle_budget + 20000) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_no, rsp_owed_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int          q;
        int          b;
        int unsigned k;
        int unsigned n;

        // Pool after reset: each queue holds its plane's blocks ascending
        for (q = 0; q < NUM_Q; q++) begin
            ring_head[q] = 0;
            ring_len[q]  = 0;
            for (b = q / FLASH_COUNT; b < BLOCKS_PER_FLASH; b += PLANE_COUNT) begin
                ring_mem[q][ring_len[q]] = BLK_W'(b);
                ring_len[q]++;
            end
        end
        pool_free = FLASH_COUNT * BLOCKS_PER_FLASH;
        free_low  = pool_free;
        rr_ptr    = 0;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Takes ignore chip and block fields: all ones, all zeros, random
        queue_request(CMD_TAKE, '1, '1, 1'b0, 1'b0);
        queue_request(CMD_TAKE, '0, '0, 1'b0, 1'b0);
        queue_request(CMD_TAKE, FLASH_W'($urandom), BLK_W'($urandom), 1'b0, 1'b0);
        // Return into a queue that is still full: dropped
        queue_request(CMD_PUT, '1, '1, 1'b0, 1'b0);
        // Return the first granted block: accepted
        queue_request(CMD_PUT, '0, '0, 1'b0, 1'b0);
        // Walk the pointer around the remaining queues and back to the first
        for (k = 0; k < 14; k++)
            queue_request(CMD_TAKE, FLASH_W'($urandom), BLK_W'($urandom), 1'b0, 1'b1);
        // Same block again: taken as a new entry, then dropped once the queue is full
        queue_request(CMD_PUT, '0, '0, 1'b0, 1'b0);
        queue_request(CMD_PUT, '0, '0, 1'b0, 1'b0);
        queue_request(CMD_PUT, '1, '0, 1'b0, 1'b0);
        queue_request(CMD_PUT, '0, '1, 1'b0, 1'b0);
        queue_request(CMD_PUT, 3'd1, '0, 1'b0, 1'b0);

        // Long receiver hold-off while requests keep coming, then mixed traffic
        hold_req = 1'b1;
        queue_mixed(MIXED_ITEMS, 55, 35);

        // Burst of takes with only short request gaps and short receiver stalls
        wait_drained();
        n = BURST_ITEMS;
        drain_lo = queued_total;
        drain_hi = queued_total + n;
        for (k = 0; k < n; k++)
            queue_request(CMD_TAKE, FLASH_W'($urandom), BLK_W'($urandom), 1'b1, 1'b0);

        // Mixed traffic again, returning many of the blocks the burst took
        queue_mixed(TAIL_ITEMS, 45, 45);

        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        $display("Run covered %0d request beats: %0d grants, %0d empty-pool takes",
                 accepted_total, grants, empty_hits);
        $display("Returns: %0d accepted, %0d dropped; low-water %0d free; %0d hold-offs",
                 returns_ok, drops, free_low, holds_done);
        if (mism_count == 0 && stray_count == 0 && rsp_owed_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("Failures: %0d mismatches, %0d unexpected, %0d missing",
                     mism_count, stray_count, rsp_owed_q.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
